// ===== rtl/key_value_line_tokenizer_core_assert.svh =====
// assertion macros for the key/value line tokenizer checker
// expects a clock i_clk and an active low reset i_rst_n in the using scope
`ifndef KEY_VALUE_LINE_TOKENIZER_CORE_ASSERT_SVH
`define KEY_VALUE_LINE_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication
`define KVLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KVLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/kvlt_pkg.sv =====
// types and constants for the key/value line tokenizer
// no dependencies
package kvlt_pkg;

    // parser state, one-hot
    typedef enum logic [4:0] {
        ST_KEY     = 5'b00001,
        ST_VALUE   = 5'b00010,
        ST_QUOTED  = 5'b00100,
        ST_ESCAPED = 5'b01000,
        ST_ERROR   = 5'b10000
    } t_state;

    // character kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_VALUE = 2'd2;

    // byte codes
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_EQUAL  = 8'd61;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_DIG_LO = 8'd48;
    localparam logic [7:0] CH_DIG_HI = 8'd57;
    localparam logic [7:0] CH_UC_LO  = 8'd65;
    localparam logic [7:0] CH_UC_HI  = 8'd90;
    localparam logic [7:0] CH_LC_LO  = 8'd97;
    localparam logic [7:0] CH_LC_HI  = 8'd122;
    localparam logic [7:0] CH_PRINT_LO = 8'd32;
    localparam logic [7:0] CH_PRINT_HI = 8'd128;

    // one result transaction
    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] char_kind;
        logic       value_break;
        logic       line_done;
        logic       final_value;
        logic       line_ok;
    } t_result;

endpackage

// ===== rtl/kvlt_if.sv =====
// valid/ready channel interfaces for the key/value line tokenizer
// no dependencies
interface kvlt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       has_byte;
    logic       line_end;

    modport source (output valid, byte_in, has_byte, line_end, input ready);
    modport sink (input valid, byte_in, has_byte, line_end, output ready);
endinterface

interface kvlt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [1:0] char_kind;
    logic       value_break;
    logic       line_done;
    logic       final_value;
    logic       line_ok;

    modport source (output valid, out_char, char_kind, value_break, line_done,
                    final_value, line_ok, input ready);
    modport sink (input valid, out_char, char_kind, value_break, line_done,
                  final_value, line_ok, output ready);
endinterface

// ===== rtl/kvlt_step.sv =====
// byte classification and next state for one input transaction
// depends on kvlt_pkg
module kvlt_step (
    input  kvlt_pkg::t_state  i_state,
    input  logic [7:0]        i_byte_in,
    input  logic              i_has_byte,
    input  logic              i_line_end,
    output kvlt_pkg::t_state  o_state,
    output kvlt_pkg::t_result o_result
);
    import kvlt_pkg::*;

    logic    is_blank;
    logic    is_alnum;
    logic    is_print;
    t_state  st_byte;
    t_result res;

    // character classes
    assign is_blank = (i_byte_in == CH_SPACE) || (i_byte_in == CH_TAB);
    assign is_alnum = ((i_byte_in >= CH_DIG_LO) && (i_byte_in <= CH_DIG_HI))
                   || ((i_byte_in >= CH_UC_LO) && (i_byte_in <= CH_UC_HI))
                   || ((i_byte_in >= CH_LC_LO) && (i_byte_in <= CH_LC_HI));
    assign is_print = (i_byte_in > CH_PRINT_LO) && (i_byte_in < CH_PRINT_HI);

    // byte handling, then line end on the updated state
    always_comb begin
        st_byte = i_state;
        res     = '0;
        if (i_has_byte) begin
            case (i_state)
                ST_KEY: begin
                    if (is_blank) begin
                        st_byte = ST_KEY;
                    end else if (is_alnum) begin
                        res.out_char  = i_byte_in;
                        res.char_kind = KIND_KEY;
                    end else if (i_byte_in == CH_EQUAL) begin
                        st_byte = ST_VALUE;
                    end else begin
                        st_byte = ST_ERROR;
                    end
                end
                ST_VALUE: begin
                    if (is_blank) begin
                        st_byte = ST_VALUE;
                    end else if (i_byte_in == CH_QUOTE) begin
                        st_byte = ST_QUOTED;
                    end else if (i_byte_in == CH_COMMA) begin
                        res.value_break = 1'b1;
                    end else if (is_print) begin
                        res.out_char  = i_byte_in;
                        res.char_kind = KIND_VALUE;
                    end else begin
                        st_byte = ST_ERROR;
                    end
                end
                ST_QUOTED: begin
                    if (i_byte_in == CH_QUOTE) begin
                        st_byte = ST_VALUE;
                    end else if (i_byte_in == CH_BSLASH) begin
                        st_byte = ST_ESCAPED;
                    end else begin
                        res.out_char  = i_byte_in;
                        res.char_kind = KIND_VALUE;
                    end
                end
                ST_ESCAPED: begin
                    res.out_char  = i_byte_in;
                    res.char_kind = KIND_VALUE;
                    st_byte       = ST_QUOTED;
                end
                default: begin
                    st_byte = ST_ERROR;
                end
            endcase
        end

        o_state = st_byte;
        if (i_line_end) begin
            res.line_done   = 1'b1;
            res.final_value = (st_byte == ST_VALUE);
            res.line_ok     = (st_byte == ST_KEY) || (st_byte == ST_VALUE)
                           || (st_byte == ST_QUOTED) || (st_byte == ST_ESCAPED);
            o_state         = ST_KEY;
        end
        o_result = res;
    end

endmodule

// ===== rtl/kvlt_skid.sv =====
// two-entry output buffer: result register plus skid stage
// depends on kvlt_pkg
module kvlt_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kvlt_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output kvlt_pkg::t_result o_data
);
    import kvlt_pkg::*;

    logic    r_main_vld, n_main_vld;
    logic    r_skid_vld, n_skid_vld;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    push;
    logic    pop;

    assign o_ready = !r_skid_vld;
    assign o_valid = r_main_vld;
    assign o_data  = r_main;
    assign push    = i_valid && !r_skid_vld;
    assign pop     = r_main_vld && i_ready;

    // buffer next state
    always_comb begin
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        n_main     = r_main;
        n_skid     = r_skid;
        if (pop) begin
            if (r_skid_vld) begin
                n_main     = r_skid;
                n_skid_vld = 1'b0;
            end else if (push) begin
                n_main = i_data;
            end else begin
                n_main_vld = 1'b0;
            end
        end else if (push) begin
            if (!r_main_vld) begin
                n_main     = i_data;
                n_main_vld = 1'b1;
            end else begin
                n_skid     = i_data;
                n_skid_vld = 1'b1;
            end
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// ===== rtl/key_value_line_tokenizer_core.sv =====
// channel    | dir | payload
// i_in       | in  | byte_in[7:0], has_byte, line_end
// o_out      | out | out_char[7:0], char_kind[1:0], value_break, line_done,
//            |     | final_value, line_ok
// one transaction in per cycle while i_in.ready is high, one result per transaction,
// held in the result register; the parser state loop closes through one register
// reset: parser to key state, output buffer empty
// a stalled output fills a two-entry buffer; i_in.ready drops only when both
// entries hold results
// top level of the key/value line tokenizer
// depends on kvlt_pkg, kvlt_if, kvlt_step, kvlt_skid
module key_value_line_tokenizer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kvlt_in_if.sink   i_in,
    kvlt_out_if.source o_out
);
    import kvlt_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result step_res;
    t_result buf_res;
    logic    in_ready;
    logic    accept;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    // decode one byte against the current state
    kvlt_step u_step (
        .i_state    (r_state),
        .i_byte_in  (i_in.byte_in),
        .i_has_byte (i_in.has_byte),
        .i_line_end (i_in.line_end),
        .o_state    (n_state),
        .o_result   (step_res)
    );

    // parser state advances on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_KEY;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // result register and skid stage
    kvlt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (in_ready),
        .i_data  (step_res),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (buf_res)
    );

    assign o_out.out_char    = buf_res.out_char;
    assign o_out.char_kind   = buf_res.char_kind;
    assign o_out.value_break = buf_res.value_break;
    assign o_out.line_done   = buf_res.line_done;
    assign o_out.final_value = buf_res.final_value;
    assign o_out.line_ok     = buf_res.line_ok;

endmodule

// ===== rtl/kvlt_checker.sv =====
// port-level checks for the key/value line tokenizer, bound to the top level
// depends on kvlt_pkg and key_value_line_tokenizer_core_assert.svh
`include "key_value_line_tokenizer_core_assert.svh"

module kvlt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic [1:0] i_char_kind,
    input logic       i_value_break,
    input logic       i_line_done,
    input logic       i_final_value,
    input logic       i_line_ok
);
    import kvlt_pkg::*;

    // no character means a zero byte, and never an unused kind code
    `KVLT_ASSERT_NOW(a_kind_char, i_out_valid, (i_char_kind != 2'd3) && ((i_char_kind != KIND_NONE) || (i_out_char == 8'd0)), "bad character kind or stray byte")

    // line status only on a line end
    `KVLT_ASSERT_NOW(a_line_flags, i_out_valid && !i_line_done, !i_final_value && !i_line_ok, "line status without line end")

    // a closed pending value only comes with a good line end
    `KVLT_ASSERT_NOW(a_final_ok, i_out_valid && i_final_value, i_line_ok && i_line_done, "final value on a bad line")

    // stalled result holds
    `KVLT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_char) && $stable(i_char_kind) && $stable(i_line_ok), "stalled result changed")

endmodule

bind key_value_line_tokenizer_core kvlt_checker u_kvlt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_char    (o_out.out_char),
    .i_char_kind   (o_out.char_kind),
    .i_value_break (o_out.value_break),
    .i_line_done   (o_out.line_done),
    .i_final_value (o_out.final_value),
    .i_line_ok     (o_out.line_ok)
);
